>>> rtl/pidsc_pkg.sv
// Shared constants for the PID speed regulator: register indices, mode codes,
// reset values and fixed-point limits. No dependencies.
`default_nettype none

package pidsc_pkg;

  // Widths of the fixed-point operands and ports
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned ERR_W     = SPEED_W + 1;
  localparam int unsigned DIFF_W    = SPEED_W + 2;
  localparam int unsigned INTEG_W   = 32;
  localparam int unsigned DRIVE_W   = 24;
  localparam int unsigned Q_SHIFT   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned MODE_W    = 2;

  // Mode codes; the unused code behaves as full PID
  localparam logic [MODE_W-1:0] MODE_P   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PI  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PID = 2'd2;

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd4;

  // Reset values of the configuration registers (Q8.8)
  localparam logic signed [SPEED_W-1:0] TARGET_RST = 16'sd256;
  localparam logic signed [SPEED_W-1:0] GAIN_P_RST = 16'sd2048;
  localparam logic signed [SPEED_W-1:0] GAIN_I_RST = 16'sd102;
  localparam logic signed [SPEED_W-1:0] GAIN_D_RST = 16'sd0;

  // Limits: 150.0 integral clamp in PI mode, 99.0 cut-off in PID mode
  localparam int PI_LIMIT  = 38400;
  localparam int PID_LIMIT = 25344;

endpackage

`default_nettype wire

>>> rtl/pid_speed_controller.sv
// Positional PID speed regulator, Q8.8 fixed point, top level.
// Throughput: one word per cycle while out_ready_i does not stall the pipe.
// The integral update is a single add and clamp.
// Stages: error and state update, gain products, sum and limit to output.
// Reset: configuration returns to PID mode with default gains, state clears.
// Depends on pidsc_pkg.
`default_nettype none

module pid_speed_controller (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // configuration write port
  input  wire                                   cfg_we_i,
  input  wire  [pidsc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [pidsc_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  // speed sample channel
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire  signed [pidsc_pkg::SPEED_W-1:0]  measured_speed_i,
  // drive channel
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic signed [pidsc_pkg::DRIVE_W-1:0]  drive_o,
  output logic                                  zeroed_o
);
  import pidsc_pkg::*;

  localparam int unsigned SUM_IW = INTEG_W + 2;
  localparam int unsigned PP_W   = SPEED_W + ERR_W;
  localparam int unsigned PI_W   = SPEED_W + INTEG_W;
  localparam int unsigned PD_W   = SPEED_W + DIFF_W;
  localparam int unsigned TP_W   = PP_W - Q_SHIFT;
  localparam int unsigned TI_W   = PI_W - Q_SHIFT;
  localparam int unsigned TD_W   = PD_W - Q_SHIFT;
  localparam int unsigned SUM_W  = TI_W + 2;

  localparam logic signed [SUM_IW-1:0] PI_HI  = SUM_IW'(PI_LIMIT);
  localparam logic signed [SUM_IW-1:0] PI_LO  = -SUM_IW'(PI_LIMIT);
  localparam logic signed [SUM_IW-1:0] I32_HI = SUM_IW'(64'sh7fffffff);
  localparam logic signed [SUM_IW-1:0] I32_LO = -SUM_IW'(64'sh80000000);
  localparam logic signed [SUM_W-1:0]  PID_HI = SUM_W'(PID_LIMIT);
  localparam logic signed [SUM_W-1:0]  PID_LO = -SUM_W'(PID_LIMIT);
  localparam logic signed [SUM_W-1:0]  DRV_HI = SUM_W'(64'sh7fffff);
  localparam logic signed [SUM_W-1:0]  DRV_LO = -SUM_W'(64'sh800000);

  // configuration registers
  logic [MODE_W-1:0]         mode_q;
  logic signed [SPEED_W-1:0] target_q, gain_p_q, gain_i_q, gain_d_q;

  // controller state
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [ERR_W-1:0]   prev_err_q, prev_err_d;

  // pipeline valids and handshake
  logic v0_q, v1_q, v2_q, vo_q;
  logic rdy1, rdy2, rdy3;
  logic in_fire, s0_adv, s1_adv, s2_adv;

  // stage payloads
  logic signed [SPEED_W-1:0] meas_q;
  logic signed [ERR_W-1:0]   s1_err_q;
  logic signed [INTEG_W-1:0] s1_integ_q;
  logic signed [DIFF_W-1:0]  s1_diff_q;
  logic signed [TP_W-1:0]    p_term_q;
  logic signed [TI_W-1:0]    i_term_q;
  logic signed [TD_W-1:0]    d_term_q;
  logic signed [DRIVE_W-1:0] drive_q, drive_d;
  logic                      zeroed_q, zeroed_d;

  // combinational stage values
  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [SUM_IW-1:0]  integ_sum;
  logic signed [PP_W-1:0]    prod_p;
  logic signed [PI_W-1:0]    prod_i;
  logic signed [PD_W-1:0]    prod_d;
  logic signed [SUM_W-1:0]   sum;

  // write configuration registers; unknown indices are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PID;
      target_q <= TARGET_RST;
      gain_p_q <= GAIN_P_RST;
      gain_i_q <= GAIN_I_RST;
      gain_d_q <= GAIN_D_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        REG_TARGET: target_q <= cfg_data_i;
        REG_GAIN_P: gain_p_q <= cfg_data_i;
        REG_GAIN_I: gain_i_q <= cfg_data_i;
        REG_GAIN_D: gain_d_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake chain: each stage advances when the next one can take its word
  assign rdy3       = !vo_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = !v0_q || rdy1;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s0_adv     = v0_q && rdy1;
  assign s1_adv     = v1_q && rdy2;
  assign s2_adv     = v2_q && rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v0_q <= in_fire || (v0_q && !s0_adv);
      v1_q <= s0_adv  || (v1_q && !s1_adv);
      v2_q <= s1_adv  || (v2_q && !s2_adv);
      vo_q <= s2_adv  || (vo_q && !(vo_q && out_ready_i));
    end
  end

  // capture the speed sample
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      meas_q <= measured_speed_i;
    end
  end

  // error, derivative difference and integral update for the mode
  always_comb begin
    err       = {target_q[SPEED_W-1], target_q} - {meas_q[SPEED_W-1], meas_q};
    diff      = {err[ERR_W-1], err} - {prev_err_q[ERR_W-1], prev_err_q};
    integ_sum = {{(SUM_IW-INTEG_W){integ_q[INTEG_W-1]}}, integ_q}
              + {{(SUM_IW-ERR_W){err[ERR_W-1]}}, err};
    integ_d    = integ_q;
    prev_err_d = prev_err_q;
    if (mode_q == MODE_PI) begin
      if (integ_sum > PI_HI) begin
        integ_d = INTEG_W'(PI_HI);
      end else if (integ_sum < PI_LO) begin
        integ_d = INTEG_W'(PI_LO);
      end else begin
        integ_d = integ_sum[INTEG_W-1:0];
      end
    end else if (mode_q != MODE_P) begin
      if (integ_sum > I32_HI) begin
        integ_d = INTEG_W'(I32_HI);
      end else if (integ_sum < I32_LO) begin
        integ_d = INTEG_W'(I32_LO);
      end else begin
        integ_d = integ_sum[INTEG_W-1:0];
      end
      prev_err_d = err;
    end
  end

  // hold state between words; advance it once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      prev_err_q <= '0;
    end else if (s0_adv) begin
      integ_q    <= integ_d;
      prev_err_q <= prev_err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_adv) begin
      s1_err_q   <= err;
      s1_integ_q <= integ_d;
      s1_diff_q  <= diff;
    end
  end

  // gain products, truncated back to Q8.8 by dropping the low bits
  assign prod_p = gain_p_q * s1_err_q;
  assign prod_i = gain_i_q * s1_integ_q;
  assign prod_d = gain_d_q * s1_diff_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      p_term_q <= prod_p[PP_W-1:Q_SHIFT];
      i_term_q <= (mode_q == MODE_P) ? '0 : prod_i[PI_W-1:Q_SHIFT];
      d_term_q <= (mode_q == MODE_P || mode_q == MODE_PI) ? '0
                                                          : prod_d[PD_W-1:Q_SHIFT];
    end
  end

  // sum the terms, then saturate or cut off depending on the mode
  always_comb begin
    sum = {{(SUM_W-TP_W){p_term_q[TP_W-1]}}, p_term_q}
        + {{(SUM_W-TI_W){i_term_q[TI_W-1]}}, i_term_q}
        + {{(SUM_W-TD_W){d_term_q[TD_W-1]}}, d_term_q};
    zeroed_d = 1'b0;
    if (mode_q == MODE_P || mode_q == MODE_PI) begin
      if (sum > DRV_HI) begin
        drive_d = DRIVE_W'(DRV_HI);
      end else if (sum < DRV_LO) begin
        drive_d = DRIVE_W'(DRV_LO);
      end else begin
        drive_d = sum[DRIVE_W-1:0];
      end
    end else if (sum > PID_HI || sum < PID_LO) begin
      drive_d  = '0;
      zeroed_d = 1'b1;
    end else begin
      drive_d = sum[DRIVE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      drive_q  <= drive_d;
      zeroed_q <= zeroed_d;
    end
  end

  assign out_valid_o = vo_q;
  assign drive_o     = drive_q;
  assign zeroed_o    = zeroed_q;

`ifndef NO_ASSERTIONS
  // a cut-off drive word carries zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zeroed_o) |-> (drive_o == '0))
    else $error("zeroed drive word is not zero");

  // the cut-off flag only arises in PID mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mode_q == MODE_P || mode_q == MODE_PI)) |-> !zeroed_o)
    else $error("zeroed flag outside PID mode");

  // a PI step leaves the integral within the clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_adv && mode_q == MODE_PI) |=>
      (integ_q <= INTEG_W'(PI_HI) && integ_q >= INTEG_W'(PI_LO)))
    else $error("PI integral outside clamp");

  // state moves only when a word leaves the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s0_adv |=> ($stable(integ_q) && $stable(prev_err_q)))
    else $error("controller state changed without a word");
`endif

endmodule

`default_nettype wire
